/* hw/rtl/all_pairs_shortest_path_top_assert.svh */
// Assertion macros for the shortest path block.
`ifndef ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_TOP_ASSERT_SVH
`ifndef SYNTH
`define APSP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apsp assertion failed");
`define APSP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apsp assertion failed");
`else
`define APSP_ASSERT_IMP(lbl, ante, cons)
`define APSP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/apsp_pkg.sv */
package apsp_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int ADDR_W = 2 * VIDX_W;
    localparam int CNT_W = 7;
    localparam int DIST_W = 32;
    localparam int HOP_W = VIDX_W + 1;
    localparam int WEIGHT_W = 16;
    localparam logic [DIST_W-1:0] DIST_INIT = 32'd32767;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_RUN   = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;
endpackage

/* hw/rtl/apsp_ram.sv */
module apsp_ram #(
    parameter int WIDTH = 32,
    parameter int AW = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/apsp_cell.sv */
module apsp_cell (
    input  logic                       clk,
    input  logic                       shift_en,
    input  logic [apsp_pkg::DIST_W-1:0] d_in,
    output logic [apsp_pkg::DIST_W-1:0] q
);
    import apsp_pkg::*;

    logic [DIST_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            val_reg <= d_in;
        end
    end

    assign q = val_reg;
endmodule

/* hw/rtl/all_pairs_shortest_path_top.sv */
// Floyd-Warshall all-pairs shortest paths, up to 64 vertices.
// Input channel (in_valid/in_ready) takes one command word: clear, add edge,
// run closure or query pair. Every command answers with exactly one result
// word on the output channel (out_valid/out_ready).
// Run streams each row through the distance RAM one column per cycle, against
// a circulating chain of 64 cells holding the current via row.
// One command is in flight at a time; a new word is taken as soon as the
// previous one has its result staged in the output register.
// After reset both RAMs are swept; in_ready stays low during the sweep.
// vertex_count (cfg_we/cfg_wdata) resets to 64; it is to be written only when idle,
// which the block does not enforce. A stalled receiver holds the result; the next
// command then waits in the final stage until the output register frees.
module all_pairs_shortest_path_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [apsp_pkg::CNT_W-1:0]    cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [apsp_pkg::VIDX_W-1:0]   src_vertex,
    input  logic [apsp_pkg::VIDX_W-1:0]   dst_vertex,
    input  logic signed [apsp_pkg::WEIGHT_W-1:0] edge_weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [apsp_pkg::DIST_W-1:0] distance,
    output logic [apsp_pkg::VIDX_W-1:0]   next_hop,
    output logic                          has_next,
    output logic                          status
);
    import apsp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_ROWRD  = 8'b0000_1000,
        S_ROWCAP = 8'b0001_0000,
        S_COL    = 8'b0010_0000,
        S_QRD    = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } state_t;

    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(MAX_VERTICES - 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] vc_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic resp_pend_reg, resp_pend_next;
    logic [VIDX_W-1:0] via_reg, via_next, row_reg, row_next, col_reg, col_next;
    logic ld_v_reg, ld_v_next, proc_v_reg, proc_v_next;
    logic [VIDX_W-1:0] pcol_reg, prow_reg, pvia_reg;
    logic [DIST_W-1:0] a_reg;
    logic [HOP_W-1:0] ha_reg;
    logic [DIST_W-1:0] p_dist_reg, p_dist_next;
    logic [VIDX_W-1:0] p_hop_reg, p_hop_next;
    logic p_has_reg, p_has_next, p_stat_reg, p_stat_next;
    logic out_valid_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [VIDX_W-1:0] out_hop_reg;
    logic out_has_reg, out_stat_reg;

    logic [CNT_W-1:0] n_act;
    logic in_fire, in_range;
    logic [ADDR_W-1:0] raddr, waddr;
    logic dist_we, hop_we;
    logic [DIST_W-1:0] dist_wdata, dist_rdata;
    logic [HOP_W-1:0] hop_wdata, hop_rdata;
    logic [DIST_W-1:0] cq [MAX_VERTICES];
    logic [DIST_W-1:0] tail_in, head;
    logic shift_en;
    logic signed [DIST_W:0] sum_wide;
    logic [DIST_W-1:0] sum_sat;
    logic upd;
    logic row_last, via_last;
    logic [VIDX_W-1:0] clr_r, clr_c;

    assign n_act = (vc_reg > MAX_CNT) ? MAX_CNT : vc_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;
    assign in_range = ({1'b0, src_vertex} < n_act) && ({1'b0, dst_vertex} < n_act);
    assign row_last = (({1'b0, row_reg} + CNT_W'(1)) >= n_act);
    assign via_last = (({1'b0, via_reg} + CNT_W'(1)) >= n_act);
    assign clr_r = clr_reg[ADDR_W-1:VIDX_W];
    assign clr_c = clr_reg[VIDX_W-1:0];

    // relaxation on the word leaving the head of the chain
    assign head = cq[0];
    assign sum_wide = $signed({a_reg[DIST_W-1], a_reg}) + $signed({head[DIST_W-1], head});
    always_comb
    begin
        if (sum_wide[DIST_W] != sum_wide[DIST_W-1])
        begin
            sum_sat = sum_wide[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}}
                                       : {1'b0, {(DIST_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[DIST_W-1:0];
        end
    end
    assign upd = proc_v_reg && ({1'b0, pcol_reg} < n_act)
              && ($signed(sum_sat) < $signed(dist_rdata));

    assign shift_en = ld_v_reg || proc_v_reg;
    assign tail_in = ld_v_reg ? dist_rdata : ((upd && (prow_reg == pvia_reg)) ? sum_sat : head);

    for (genvar i = 0; i < MAX_VERTICES; i++)
    begin : g_chain
        apsp_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d_in     ((i == MAX_VERTICES - 1) ? tail_in : cq[(i + 1) % MAX_VERTICES]),
            .q        (cq[i])
        );
    end

    // RAM port control
    always_comb
    begin
        raddr = {src_vertex, dst_vertex};
        waddr = {prow_reg, pcol_reg};
        dist_we = 1'b0;
        hop_we = 1'b0;
        dist_wdata = sum_sat;
        hop_wdata = ha_reg;
        if (state_reg == S_CLEAR)
        begin
            waddr = clr_reg;
            dist_we = 1'b1;
            hop_we = 1'b1;
            dist_wdata = DIST_INIT;
            hop_wdata = (clr_r != clr_c) ? ({1'b0, clr_c} + HOP_W'(1)) : '0;
        end
        else if (upd)
        begin
            dist_we = 1'b1;
            hop_we = 1'b1;
        end
        else if (in_fire && (command == CMD_ADD) && in_range)
        begin
            waddr = {src_vertex, dst_vertex};
            dist_we = 1'b1;
            dist_wdata = {{(DIST_W-WEIGHT_W){edge_weight[WEIGHT_W-1]}}, edge_weight};
        end
        if (state_reg == S_LOAD)
        begin
            raddr = {via_reg, col_reg};
        end
        else if (state_reg == S_ROWRD)
        begin
            raddr = {row_reg, via_reg};
        end
        else if (state_reg == S_COL)
        begin
            raddr = {row_reg, col_reg};
        end
    end

    apsp_ram #(.WIDTH(DIST_W), .AW(ADDR_W)) u_dist_ram (
        .clk   (clk),
        .we    (dist_we),
        .waddr (waddr),
        .wdata (dist_wdata),
        .raddr (raddr),
        .rdata (dist_rdata)
    );

    apsp_ram #(.WIDTH(HOP_W), .AW(ADDR_W)) u_hop_ram (
        .clk   (clk),
        .we    (hop_we),
        .waddr (waddr),
        .wdata (hop_wdata),
        .raddr (raddr),
        .rdata (hop_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        resp_pend_next = resp_pend_reg;
        via_next = via_reg;
        row_next = row_reg;
        col_next = col_reg;
        ld_v_next = 1'b0;
        proc_v_next = 1'b0;
        p_dist_next = p_dist_reg;
        p_hop_next = p_hop_reg;
        p_has_next = p_has_reg;
        p_stat_next = p_stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    p_dist_next = '0;
                    p_hop_next = '0;
                    p_has_next = 1'b0;
                    p_stat_next = 1'b0;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            clr_next = '0;
                            resp_pend_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        CMD_ADD:
                        begin
                            p_stat_next = !in_range;
                            state_next = S_RESP;
                        end
                        CMD_RUN:
                        begin
                            via_next = '0;
                            row_next = '0;
                            col_next = '0;
                            state_next = (n_act == '0) ? S_RESP : S_LOAD;
                        end
                        default:
                        begin
                            p_stat_next = !in_range;
                            state_next = in_range ? S_QRD : S_RESP;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = resp_pend_reg ? S_RESP : S_IDLE;
                    resp_pend_next = 1'b0;
                end
            end
            S_LOAD:
            begin
                ld_v_next = 1'b1;
                col_next = col_reg + VIDX_W'(1);
                if (col_reg == LAST_IDX)
                begin
                    state_next = S_ROWRD;
                end
            end
            S_ROWRD:
            begin
                state_next = S_ROWCAP;
            end
            S_ROWCAP:
            begin
                state_next = S_COL;
            end
            S_COL:
            begin
                proc_v_next = 1'b1;
                col_next = col_reg + VIDX_W'(1);
                if (col_reg == LAST_IDX)
                begin
                    if (!row_last)
                    begin
                        row_next = row_reg + VIDX_W'(1);
                        state_next = S_ROWRD;
                    end
                    else if (!via_last)
                    begin
                        via_next = via_reg + VIDX_W'(1);
                        row_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_QRD:
            begin
                p_dist_next = dist_rdata;
                p_has_next = (hop_rdata != '0);
                p_hop_next = VIDX_W'(hop_rdata - HOP_W'(1));
                if (hop_rdata == '0)
                begin
                    p_hop_next = '0;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            vc_reg <= MAX_CNT;
            clr_reg <= '0;
            resp_pend_reg <= 1'b0;
            via_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            ld_v_reg <= 1'b0;
            proc_v_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_wdata;
            end
            clr_reg <= clr_next;
            resp_pend_reg <= resp_pend_next;
            via_reg <= via_next;
            row_reg <= row_next;
            col_reg <= col_next;
            ld_v_reg <= ld_v_next;
            proc_v_reg <= proc_v_next;
            if ((state_reg == S_RESP) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_dist_reg <= p_dist_next;
        p_hop_reg <= p_hop_next;
        p_has_reg <= p_has_next;
        p_stat_reg <= p_stat_next;
        pcol_reg <= col_reg;
        prow_reg <= row_reg;
        pvia_reg <= via_reg;
        if (state_reg == S_ROWCAP)
        begin
            a_reg <= dist_rdata;
            ha_reg <= hop_rdata;
        end
        else if (upd && (pcol_reg == pvia_reg))
        begin
            a_reg <= sum_sat;
        end
        if ((state_reg == S_RESP) && (!out_valid_reg || out_ready))
        begin
            out_dist_reg <= p_dist_reg;
            out_hop_reg <= p_hop_reg;
            out_has_reg <= p_has_reg;
            out_stat_reg <= p_stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance = out_dist_reg;
    assign next_hop = out_hop_reg;
    assign has_next = out_has_reg;
    assign status = out_stat_reg;

`include "all_pairs_shortest_path_top_assert.svh"

    `APSP_ASSERT_IMP(a_chain_one_src, ld_v_reg, !proc_v_reg)
    `APSP_ASSERT_IMP(a_proc_phase, proc_v_reg,
        (state_reg == S_COL) || (state_reg == S_ROWRD) || (state_reg == S_LOAD) ||
        (state_reg == S_RESP))
    `APSP_ASSERT_IMP(a_rise_from_resp, $rose(out_valid_reg), $past(state_reg == S_RESP))
    `APSP_ASSERT_NXT(a_clear_quiet, (state_reg == S_CLEAR), !upd)
endmodule
